@@ rtl/ttbce_pkg.sv @@
package ttbce_pkg;

    localparam int ROUNDS    = 10;
    localparam int KEY_WORDS = 4 * (ROUNDS + 1);
    localparam int KEY_AW    = $clog2(KEY_WORDS);
    localparam int RND_W     = $clog2(ROUNDS + 1);
    localparam int TBL_DEPTH = 256;
    localparam int TBL_AW    = 8;
    localparam int WORD_W    = 32;
    localparam int PHASE_W   = 3;
    localparam int LAST_PHASE = 4;

    typedef enum logic [1:0] {
        OP_LOAD_MAIN  = 2'd0,
        OP_LOAD_FINAL = 2'd1,
        OP_LOAD_KEY   = 2'd2,
        OP_ENCRYPT    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    typedef struct packed {
        op_t         opcode;
        logic [1:0]  table_select;
        logic [7:0]  entry_index;
        logic [31:0] entry_word;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } req_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } rsp_t;

endpackage

@@ rtl/ttbce_ram.sv @@
module ttbce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/ttable_block_cipher_engine_top.sv @@
// T-table block encryption engine. Load transfers (main table, final table, round key) are
// taken while idle and give no result; a round-key load beyond the key store is dropped.
// An encrypt transfer runs the whitening pass and ROUNDS table rounds. In each pass one
// column of four table lookups and a round-key word is read per cycle from the table and
// key memories; each has a single registered read port, so a column's new word is formed
// in the cycle after its read, and the pass closes with the last column. After the final
// pass the result is moved into the output register once that register is free; the next
// transfer is taken as soon as that register is loaded, even while the result still waits.
// Memories need no clearing: a table entry or key word must be written before an encrypt reads it.
module ttable_block_cipher_engine_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  ttbce_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output ttbce_pkg::rsp_t rsp
);

    import ttbce_pkg::*;

    state_t                     state_reg, state_next;
    logic [PHASE_W-1:0]         phase_reg, phase_next;
    logic [RND_W-1:0]           round_reg, round_next;
    logic [3:0][WORD_W-1:0]     cols_reg;
    logic [3:0][WORD_W-1:0]     nxt_reg;
    rsp_t                       rsp_reg;
    logic                       rsp_valid_reg, rsp_valid_next;

    logic                       accept;
    logic [1:0]                 col_issue;
    logic [1:0]                 col_done;
    logic [3:0][TBL_AW-1:0]     tbl_raddr;
    logic [3:0][WORD_W-1:0]     main_rd;
    logic [3:0][WORD_W-1:0]     final_rd;
    logic [WORD_W-1:0]          key_rd;
    logic [KEY_AW-1:0]          key_raddr;
    logic                       key_we;
    logic [WORD_W-1:0]          lookup_word;
    logic [WORD_W-1:0]          new_col;
    logic                       final_round;
    logic                       whiten;
    logic                       pass_end;
    logic                       rsp_load;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign col_issue   = phase_reg[1:0];
    assign col_done    = 2'(phase_reg - PHASE_W'(1));
    assign final_round = (round_reg == RND_W'(ROUNDS));
    assign whiten      = (round_reg == '0);
    assign pass_end    = (state_reg == ST_RUN) && (phase_reg == PHASE_W'(LAST_PHASE));
    assign rsp_load    = (state_reg == ST_HOLD) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        logic [1:0] src;
        for (int j = 0; j < 4; j++)
        begin
            src          = col_issue + 2'(j);
            tbl_raddr[j] = cols_reg[src][WORD_W-1-8*j -: TBL_AW];
        end
    end

    assign key_raddr = KEY_AW'({round_reg, col_issue});
    assign key_we    = accept && (req.opcode == OP_LOAD_KEY)
                       && ({1'b0, req.entry_index} < 9'(KEY_WORDS));

    genvar t;
    generate
        for (t = 0; t < 4; t++)
        begin : g_tables
            ttbce_ram #(
                .WIDTH (WORD_W),
                .DEPTH (TBL_DEPTH)
            ) u_main (
                .clk   (clk),
                .we    (accept && (req.opcode == OP_LOAD_MAIN)
                        && (req.table_select == 2'(t))),
                .waddr (req.entry_index),
                .wdata (req.entry_word),
                .raddr (tbl_raddr[t]),
                .rdata (main_rd[t])
            );

            ttbce_ram #(
                .WIDTH (WORD_W),
                .DEPTH (TBL_DEPTH)
            ) u_final (
                .clk   (clk),
                .we    (accept && (req.opcode == OP_LOAD_FINAL)
                        && (req.table_select == 2'(t))),
                .waddr (req.entry_index),
                .wdata (req.entry_word),
                .raddr (tbl_raddr[t]),
                .rdata (final_rd[t])
            );
        end
    endgenerate

    ttbce_ram #(
        .WIDTH (WORD_W),
        .DEPTH (KEY_WORDS)
    ) u_key (
        .clk   (clk),
        .we    (key_we),
        .waddr (req.entry_index[KEY_AW-1:0]),
        .wdata (req.entry_word),
        .raddr (key_raddr),
        .rdata (key_rd)
    );

    always_comb
    begin
        lookup_word = '0;
        for (int j = 0; j < 4; j++)
        begin
            lookup_word = lookup_word ^ (final_round ? final_rd[j] : main_rd[j]);
        end
        new_col = (whiten ? cols_reg[col_done] : lookup_word) ^ key_rd;
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        round_next     = round_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.opcode == OP_ENCRYPT))
                begin
                    state_next = ST_RUN;
                    phase_next = '0;
                    round_next = '0;
                end
            end
            ST_RUN:
            begin
                if (pass_end)
                begin
                    phase_next = '0;
                    if (final_round)
                    begin
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        round_next = round_reg + RND_W'(1);
                    end
                end
                else
                begin
                    phase_next = phase_reg + PHASE_W'(1);
                end
            end
            ST_HOLD:
            begin
                if (rsp_load)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            round_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            round_reg     <= round_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (req.opcode == OP_ENCRYPT))
        begin
            cols_reg[0] <= req.block_high[63:32];
            cols_reg[1] <= req.block_high[31:0];
            cols_reg[2] <= req.block_low[63:32];
            cols_reg[3] <= req.block_low[31:0];
        end
        else if (pass_end)
        begin
            cols_reg[0] <= nxt_reg[0];
            cols_reg[1] <= nxt_reg[1];
            cols_reg[2] <= nxt_reg[2];
            cols_reg[3] <= new_col;
        end

        if ((state_reg == ST_RUN) && (phase_reg != '0))
        begin
            nxt_reg[col_done] <= new_col;
        end

        if (rsp_load)
        begin
            rsp_reg.cipher_high <= {cols_reg[0], cols_reg[1]};
            rsp_reg.cipher_low  <= {cols_reg[2], cols_reg[3]};
        end
    end

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (phase_reg <= PHASE_W'(LAST_PHASE)))
        else $error("pass phase out of range");

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (round_reg <= RND_W'(ROUNDS)))
        else $error("round counter out of range");

    a_hold_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) && pass_end && final_round |=> (state_reg == ST_HOLD))
        else $error("final pass did not close the encryption");

    a_rsp_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_HOLD))
        else $error("result raised outside hold");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) && !pass_end |=> !req_ready)
        else $error("request taken during encryption");

endmodule

@@ sim/ttbce_cipher_checker.sv @@
`timescale 1ns / 100ps

module ttbce_cipher_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  ttbce_pkg::req_t   req,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  ttbce_pkg::rsp_t   rsp,
    output int                mismatches,
    output int                cipher_pending
);

    import ttbce_pkg::*;

    logic [31:0] main_tbl [4][TBL_DEPTH];
    logic [31:0] last_tbl [4][TBL_DEPTH];
    logic [31:0] round_key [KEY_WORDS];
    rsp_t        cipher_expected [$];

    function automatic logic [127:0] table_round(input logic [127:0] blk, input int rnd);
        logic [127:0] nxt;
        logic [7:0]   b0;
        logic [7:0]   b1;
        logic [7:0]   b2;
        logic [7:0]   b3;
        for (int c = 0; c < 4; c++)
        begin
            b0 = blk[127 - 8 * (4 * c) -: 8];
            b1 = blk[127 - 8 * ((4 * c + 5) % 16) -: 8];
            b2 = blk[127 - 8 * ((4 * c + 10) % 16) -: 8];
            b3 = blk[127 - 8 * ((4 * c + 15) % 16) -: 8];
            if (rnd == ROUNDS)
                nxt[127 - 32 * c -: 32] = last_tbl[0][b0] ^ last_tbl[1][b1]
                                        ^ last_tbl[2][b2] ^ last_tbl[3][b3]
                                        ^ round_key[4 * rnd + c];
            else
                nxt[127 - 32 * c -: 32] = main_tbl[0][b0] ^ main_tbl[1][b1]
                                        ^ main_tbl[2][b2] ^ main_tbl[3][b3]
                                        ^ round_key[4 * rnd + c];
        end
        return nxt;
    endfunction

    function automatic rsp_t encrypt_block(input logic [63:0] hi, input logic [63:0] lo);
        logic [127:0] blk;
        rsp_t         ct;
        blk = {hi, lo} ^ {round_key[0], round_key[1], round_key[2], round_key[3]};
        for (int r = 1; r <= ROUNDS; r++)
            blk = table_round(blk, r);
        ct.cipher_high = blk[127:64];
        ct.cipher_low  = blk[63:0];
        return ct;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            cipher_expected.delete();
            mismatches     = 0;
            cipher_pending = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (cipher_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected cipher transfer: %h %h",
                                 rsp.cipher_high, rsp.cipher_low);
                end
                else
                begin
                    want = cipher_expected.pop_front();
                    if (rsp.cipher_high !== want.cipher_high
                        || rsp.cipher_low !== want.cipher_low)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("cipher mismatch: expected %h %h, got %h %h",
                                     want.cipher_high, want.cipher_low,
                                     rsp.cipher_high, rsp.cipher_low);
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                case (req.opcode)
                    OP_LOAD_MAIN:
                        main_tbl[req.table_select][req.entry_index] = req.entry_word;
                    OP_LOAD_FINAL:
                        last_tbl[req.table_select][req.entry_index] = req.entry_word;
                    OP_LOAD_KEY:
                        if (req.entry_index < KEY_WORDS)
                            round_key[req.entry_index] = req.entry_word;
                    OP_ENCRYPT:
                        cipher_expected.push_back(encrypt_block(req.block_high, req.block_low));
                    default:
                        ;
                endcase
            end
            cipher_pending = cipher_expected.size();
        end
    end

endmodule

@@ sim/ttable_block_cipher_engine_top_tb.sv @@
`timescale 1ns / 100ps

module ttable_block_cipher_engine_top_tb;

    import ttbce_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 2000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_ready;
    rsp_t        rsp;
    int          mismatches;
    int          cipher_pending;
    bit          idling_on;
    int unsigned cycle_count = 0;

    ttable_block_cipher_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    ttbce_cipher_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp),
        .mismatches     (mismatches),
        .cipher_pending (cipher_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic req_t load_item(input op_t op, input logic [1:0] sel,
                                       input logic [7:0] idx, input logic [31:0] word);
        req_t item;
        item.opcode       = op;
        item.table_select = sel;
        item.entry_index  = idx;
        item.entry_word   = word;
        item.block_high   = {$urandom, $urandom};
        item.block_low    = {$urandom, $urandom};
        return item;
    endfunction

    function automatic req_t encrypt_item(input logic [63:0] hi, input logic [63:0] lo);
        req_t item;
        item.opcode       = OP_ENCRYPT;
        item.table_select = 2'($urandom);
        item.entry_index  = 8'($urandom);
        item.entry_word   = $urandom;
        item.block_high   = hi;
        item.block_low    = lo;
        return item;
    endfunction

    // call at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input req_t item);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int stall;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idling_on && $urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(1, 6);
                rsp_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready <= 1'b1;
        end
    end

    initial
    begin
        int accepted_items;
        int pick;
        req_valid = 1'b0;
        req       = '0;
        rst_n     = 1'b0;
        idling_on = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        idling_on = 1'b1;

        // fill every table entry and key word before the first encrypt
        for (int s = 0; s < 4; s++)
            for (int i = 0; i < TBL_DEPTH; i++)
                send_item(load_item(OP_LOAD_MAIN, 2'(s), 8'(i), $urandom));
        for (int s = 0; s < 4; s++)
            for (int i = 0; i < TBL_DEPTH; i++)
                send_item(load_item(OP_LOAD_FINAL, 2'(s), 8'(i), $urandom));
        for (int k = 0; k < KEY_WORDS; k++)
            send_item(load_item(OP_LOAD_KEY, 2'($urandom), 8'(k), $urandom));

        send_item(encrypt_item(64'h0, 64'h0));
        send_item(encrypt_item('1, '1));
        send_item(load_item(OP_LOAD_MAIN, 2'd0, 8'd0, 32'h0000_0000));
        send_item(load_item(OP_LOAD_MAIN, 2'd3, 8'd255, 32'hffff_ffff));
        send_item(load_item(OP_LOAD_FINAL, 2'd0, 8'd255, 32'hffff_ffff));
        send_item(load_item(OP_LOAD_FINAL, 2'd3, 8'd0, 32'h0000_0000));
        send_item(load_item(OP_LOAD_KEY, 2'd3, 8'd0, 32'hffff_ffff));
        send_item(load_item(OP_LOAD_KEY, 2'd0, 8'(KEY_WORDS - 1), 32'h0000_0000));
        send_item(load_item(OP_LOAD_KEY, 2'd1, 8'(KEY_WORDS), 32'h1234_5678));
        send_item(load_item(OP_LOAD_KEY, 2'd2, 8'd255, 32'hffff_ffff));
        send_item(encrypt_item(64'h0, 64'h0));
        send_item(encrypt_item('1, '1));
        send_item(encrypt_item(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f));
        send_item(encrypt_item(64'h0f0e_0d0c_0b0a_0908, 64'h0706_0504_0302_0100));
        send_item(encrypt_item(64'hffff_ffff_0000_0000, 64'h0000_0000_ffff_ffff));
        send_item(encrypt_item({$urandom, $urandom}, {$urandom, $urandom}));

        accepted_items = 0;
        while (accepted_items < RANDOM_ITEMS)
        begin
            idling_on = (accepted_items < RANDOM_ITEMS - 300)
                        && ((accepted_items / 300) % 3 != 2);
            if (accepted_items == RANDOM_ITEMS / 2 && cipher_pending != 0)
            begin
                // hold off until every result has come
                req_valid <= 1'b0;
                while (cipher_pending != 0)
                    @(negedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_item(encrypt_item({$urandom, $urandom}, {$urandom, $urandom}));
            else if (pick < 65)
                send_item(load_item(OP_LOAD_MAIN, 2'($urandom), 8'($urandom), $urandom));
            else if (pick < 85)
                send_item(load_item(OP_LOAD_FINAL, 2'($urandom), 8'($urandom), $urandom));
            else if (pick < 95)
                send_item(load_item(OP_LOAD_KEY, 2'($urandom),
                                    8'($urandom_range(0, KEY_WORDS - 1)), $urandom));
            else
            begin
                send_item(load_item(OP_LOAD_KEY, 2'($urandom),
                                    8'($urandom_range(KEY_WORDS, 255)), $urandom));
                accepted_items--;
            end
            accepted_items++;
        end

        req_valid <= 1'b0;
        while (cipher_pending != 0)
            @(negedge clk);
        repeat (64) @(negedge clk);
        if (mismatches == 0 && cipher_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ttbce_pkg.sv
rtl/ttbce_ram.sv
rtl/ttable_block_cipher_engine_top.sv
sim/ttbce_cipher_checker.sv
sim/ttable_block_cipher_engine_top_tb.sv
